// ===== sv/rlc_pkg.sv =====
// shared widths and types for the resonance line clipper
package rlc_pkg;

  localparam int COEF_W = 8;
  localparam int RHS_W  = 9;
  localparam int OFF_W  = 24;
  localparam int OUT_W  = 25;
  localparam int DIV_W  = 8;   // normalized numerator and denominator, at most 128

  localparam logic REG_X_OFFSET = 1'b0;
  localparam logic REG_Y_OFFSET = 1'b1;

  typedef struct packed {
    logic             ok;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } edge_req_t;

endpackage

// ===== sv/rlc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, for 0 <= num <= den
module rlc_div import rlc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic               ok_in,
  input  logic [DIV_W-1:0]   num,
  input  logic [DIV_W-1:0]   den,
  output logic               ok_out,
  output logic [FRAC_BITS:0] quo
);

  localparam int NS = FRAC_BITS + 1;

  logic [DIV_W-1:0]   rem_r [NS];
  logic [DIV_W-1:0]   den_r [NS];
  logic [FRAC_BITS:0] quo_r [NS];
  logic               ok_r  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DIV_W:0]     r_in;
    logic [DIV_W-1:0]   d_in;
    logic [FRAC_BITS:0] q_in;
    logic               o_in;
    logic               bit_q;

    if (s == 0) begin : g_first
      assign r_in = {1'b0, num};
      assign d_in = den;
      assign q_in = '0;
      assign o_in = ok_in;
    end else begin : g_next
      assign r_in = {rem_r[s-1], 1'b0};
      assign d_in = den_r[s-1];
      assign q_in = quo_r[s-1];
      assign o_in = ok_r[s-1];
    end

    assign bit_q = (r_in >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= bit_q ? DIV_W'(r_in - {1'b0, d_in}) : DIV_W'(r_in);
        den_r[s] <= d_in;
        quo_r[s] <= {q_in[FRAC_BITS-1:0], bit_q};
        ok_r[s]  <= o_in;
      end
    end
  end

  assign quo    = quo_r[NS-1];
  assign ok_out = ok_r[NS-1];

endmodule

// ===== sv/resonance_line_clip_unit_square.sv =====
// top level: clips a resonance line to the unit square and adds offsets
// usage:
//   input channel in_valid/in_stall carries coef_x, coef_y, order_rhs (signed)
//   result channel out_valid/out_stall carries both endpoints and visible
//   one result per request, in order
//   pipeline: input register, FRAC_BITS+1 divider
//   stages (one quotient bit each), a compare stage and the output register
//   throughput is one request per cycle unless stalled, set by the bit-per-stage dividers
//   four dividers run side by side, one per edge of the square
//   the whole pipeline advances together; when the output holds a result
//   and out_stall is high everything freezes and in_stall goes high,
//   so nothing is lost or repeated
//   reset clears all valid bits and both offset registers; in_stall is
//   held high while reset is asserted
//   cfg_we writes x_offset (index 0) or y_offset (index 1);
//   write only while the pipeline is empty
//   invisible lines give both points at (0,0) plus the offsets
module resonance_line_clip_unit_square import rlc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [OFF_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [COEF_W-1:0] in_coef_x,
  input  logic signed [COEF_W-1:0] in_coef_y,
  input  logic signed [RHS_W-1:0]  in_order_rhs,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OUT_W-1:0]         out_first_x,
  output logic [OUT_W-1:0]         out_first_y,
  output logic [OUT_W-1:0]         out_second_x,
  output logic [OUT_W-1:0]         out_second_y,
  output logic                     out_visible
);

  localparam int CW  = FRAC_BITS + 1;
  localparam int NDV = FRAC_BITS + 1;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

  // pipeline enable: freeze when a finished result is held and out_stall is high
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en || !rst_n;

  // offset registers
  logic [OFF_W-1:0] x_off_r, y_off_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r <= '0;
      y_off_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_OFFSET: x_off_r <= cfg_wdata;
        REG_Y_OFFSET: y_off_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sign-normalize num/den and test 0 <= num/den <= 1
  function automatic edge_req_t edge_prep(logic signed [9:0] num_i,
                                          logic signed [7:0] den_i);
    logic signed [10:0] n;
    logic signed [8:0]  d;
    edge_req_t          r;
    n = den_i[7] ? -11'(num_i) : 11'(num_i);
    d = den_i[7] ? -9'(den_i)  : 9'(den_i);
    r.ok  = (d != 9'sd0) && (n >= 11'sd0) && (n <= 11'(d));
    r.num = DIV_W'(n);
    r.den = DIV_W'(d);
    return r;
  endfunction

  logic signed [9:0] rhs_w, rhs_mx, rhs_my;
  assign rhs_w  = 10'(in_order_rhs);
  assign rhs_my = rhs_w - 10'(in_coef_y);
  assign rhs_mx = rhs_w - 10'(in_coef_x);

  // edges: x=0, y=0, x=1, y=1
  edge_req_t req_r [4];
  logic      in_vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      req_r[0] <= edge_prep(rhs_w,  in_coef_y);
      req_r[1] <= edge_prep(rhs_w,  in_coef_x);
      req_r[2] <= edge_prep(rhs_mx, in_coef_y);
      req_r[3] <= edge_prep(rhs_my, in_coef_x);
    end
  end

  // dividers
  logic [CW-1:0] quo [4];
  logic          qok [4];
  for (genvar e = 0; e < 4; e++) begin : g_div
    rlc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk    (clk),
      .en     (en),
      .ok_in  (req_r[e].ok),
      .num    (req_r[e].num),
      .den    (req_r[e].den),
      .ok_out (qok[e]),
      .quo    (quo[e])
    );
  end

  logic dv_vld_r [NDV];
  for (genvar s = 0; s < NDV; s++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[s] <= 1'b0;
      end else if (en) begin
        dv_vld_r[s] <= (s == 0) ? in_vld_r : dv_vld_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  // candidate points, one per edge of the square
  logic [CW-1:0] px [4];
  logic [CW-1:0] py [4];
  assign px[0] = '0;     assign py[0] = quo[0];
  assign px[1] = quo[1]; assign py[1] = '0;
  assign px[2] = ONE;    assign py[2] = quo[2];
  assign px[3] = quo[3]; assign py[3] = ONE;

  // compare stage: pairwise lex order and equality
  logic [CW-1:0] px_r [4];
  logic [CW-1:0] py_r [4];
  logic [3:0]    pv_r;
  logic [3:0]    lt_r [4];
  logic [3:0]    eq_r [4];
  logic          cmp_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else if (en) begin
      cmp_vld_r <= dv_vld_r[NDV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        px_r[i] <= px[i];
        py_r[i] <= py[i];
        pv_r[i] <= qok[i];
        for (int j = 0; j < 4; j++) begin
          lt_r[i][j] <= (px[i] < px[j]) || (px[i] == px[j] && py[i] < py[j]);
          eq_r[i][j] <= (px[i] == px[j]) && (py[i] == py[j]);
        end
      end
    end
  end

  // select logic (combinational): count distinct points, pick min and max
  logic [2:0]    uniq;
  logic [1:0]    min_i, max_i;
  logic          vis;
  logic [CW-1:0] p1x, p1y, p2x, p2y;

  always_comb begin
    logic dup;
    logic is_min, is_max;
    uniq  = '0;
    min_i = '0;
    max_i = '0;
    for (int i = 3; i >= 0; i--) begin
      dup    = 1'b0;
      is_min = pv_r[i];
      is_max = pv_r[i];
      for (int j = 0; j < 4; j++) begin
        if (j < i && pv_r[j] && eq_r[i][j]) dup = 1'b1;
        if (pv_r[j] && lt_r[j][i]) is_min = 1'b0;
        if (pv_r[j] && lt_r[i][j]) is_max = 1'b0;
      end
      if (pv_r[i] && !dup) uniq = uniq + 3'd1;
      if (is_min) min_i = 2'(i);
      if (is_max) max_i = 2'(i);
    end
    vis = (uniq == 3'd2);
    p1x = vis ? px_r[min_i] : '0;
    p1y = vis ? py_r[min_i] : '0;
    p2x = vis ? px_r[max_i] : '0;
    p2y = vis ? py_r[max_i] : '0;
  end

  // output register with offsets, sums fit the output width
  logic             out_vld_r;
  logic [OUT_W-1:0] fx_r, fy_r, sx_r, sy_r;
  logic             vis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= cmp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx_r  <= OUT_W'(x_off_r) + OUT_W'(p1x);
      fy_r  <= OUT_W'(y_off_r) + OUT_W'(p1y);
      sx_r  <= OUT_W'(x_off_r) + OUT_W'(p2x);
      sy_r  <= OUT_W'(y_off_r) + OUT_W'(p2y);
      vis_r <= vis;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_first_x  = fx_r;
  assign out_first_y  = fy_r;
  assign out_second_x = sx_r;
  assign out_second_y = sy_r;
  assign out_visible  = vis_r;

endmodule

// ===== tb/testbench.sv =====
// testbench for the resonance line clipper: directed table, random lines, scoreboard
`timescale 1ns / 100ps

module testbench;
  import rlc_pkg::*;

  localparam int FRAC = 16;
  localparam logic [OUT_W-1:0] ONE_FX = 25'(1) << FRAC;
  localparam int LATENCY = FRAC + 4;

  typedef struct packed {
    logic [OUT_W-1:0] fx, fy, sx, sy;
    logic             vis;
  } clip_res_t;

  typedef struct {
    int               nx, ny, n;
    logic             chk;   // typed-in expectation present
    clip_res_t        res;
  } line_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_X_OFFSET;
  logic [OFF_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COEF_W-1:0] in_coef_x = '0;
  logic signed [COEF_W-1:0] in_coef_y = '0;
  logic signed [RHS_W-1:0] in_order_rhs = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_W-1:0] out_first_x, out_first_y, out_second_x, out_second_y;
  logic out_visible;

  // offsets as the predictor sees them
  logic [OFF_W-1:0] x_off = '0, y_off = '0;
  clip_res_t endpoint_q[$];
  line_row_t rows[$];
  int n_errors = 0;
  int stall_pct = 0;

  resonance_line_clip_unit_square #(.FRAC_BITS(FRAC)) i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("resonance_line_clip_unit_square verification failed");
    $finish;
  end

  // exact range test 0 <= num/den <= 1 with truncated fixed-point quotient
  function automatic logic edge_cut(int num, int den, output logic [OUT_W-1:0] q);
    longint unsigned t;
    q = '0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (den == 0 || num < 0 || num > den) return 1'b0;
    t = (longint'(num) << FRAC) / longint'(den);
    q = t[OUT_W-1:0];
    return 1'b1;
  endfunction

  function automatic clip_res_t clip_line(int nx, int ny, int n);
    logic [OUT_W-1:0] px[4], py[4], q, tx, ty;
    logic [OUT_W-1:0] ux[4], uy[4];
    int cnt, uniq, j;
    clip_res_t r;
    cnt = 0;
    if (nx == 0 && ny == 0) begin
      cnt = 0;
    end else if (nx == 0) begin
      if (edge_cut(n, ny, q)) begin
        px[0] = '0; py[0] = q; px[1] = ONE_FX; py[1] = q; cnt = 2;
      end
    end else if (ny == 0) begin
      if (edge_cut(n, nx, q)) begin
        px[0] = q; py[0] = '0; px[1] = q; py[1] = ONE_FX; cnt = 2;
      end
    end else begin
      if (edge_cut(n, ny, q)) begin px[cnt] = '0; py[cnt] = q; cnt++; end
      if (edge_cut(n, nx, q)) begin px[cnt] = q; py[cnt] = '0; cnt++; end
      if (edge_cut(n - nx, ny, q)) begin px[cnt] = ONE_FX; py[cnt] = q; cnt++; end
      if (edge_cut(n - ny, nx, q)) begin px[cnt] = q; py[cnt] = ONE_FX; cnt++; end
    end
    // insertion sort by x then y
    for (int i = 1; i < cnt; i++) begin
      tx = px[i]; ty = py[i]; j = i - 1;
      while (j >= 0 && (tx < px[j] || (tx == px[j] && ty < py[j]))) begin
        px[j+1] = px[j]; py[j+1] = py[j]; j--;
      end
      px[j+1] = tx; py[j+1] = ty;
    end
    uniq = 0;
    for (int i = 0; i < cnt; i++)
      if (uniq == 0 || px[i] != ux[uniq-1] || py[i] != uy[uniq-1]) begin
        ux[uniq] = px[i]; uy[uniq] = py[i]; uniq++;
      end
    r.vis = (uniq == 2);
    r.fx = x_off + (r.vis ? ux[0] : '0);
    r.fy = y_off + (r.vis ? uy[0] : '0);
    r.sx = x_off + (r.vis ? ux[1] : '0);
    r.sy = y_off + (r.vis ? uy[1] : '0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    n_errors++;
  endtask

  // no gap half the time, else mostly short gaps and a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stall, compare accepted results with oldest expectation
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (endpoint_q.size() == 0) begin
          report_mismatch("unexpected result", out_first_x, '0);
        end else begin
          clip_res_t e;
          e = endpoint_q.pop_front();
          if (out_first_x !== e.fx) report_mismatch("first_x", out_first_x, e.fx);
          if (out_first_y !== e.fy) report_mismatch("first_y", out_first_y, e.fy);
          if (out_second_x !== e.sx) report_mismatch("second_x", out_second_x, e.sx);
          if (out_second_y !== e.sy) report_mismatch("second_y", out_second_y, e.sy);
          if (out_visible !== e.vis) report_mismatch("visible", out_visible, e.vis);
        end
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        hold = gap_len();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one request, held until accepted, then an optional gap
  task automatic send_line(int nx, int ny, int n, logic chk, clip_res_t typed);
    clip_res_t p;
    clip_res_t want;
    int g;
    in_coef_x <= nx[COEF_W-1:0];
    in_coef_y <= ny[COEF_W-1:0];
    in_order_rhs <= n[RHS_W-1:0];
    in_valid <= 1'b1;
    p = clip_line(nx, ny, n);
    do @(posedge clk); while (in_stall);
    want = chk ? typed : p;
    endpoint_q = {endpoint_q, want};
    if (chk && p != typed) $display("note: typed row differs from prediction");
    g = (stall_pct == 0) ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (endpoint_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_offsets(logic [OFF_W-1:0] xo, logic [OFF_W-1:0] yo);
    cfg_we <= 1'b1; cfg_index <= REG_X_OFFSET; cfg_wdata <= xo;
    @(posedge clk);
    cfg_index <= REG_Y_OFFSET; cfg_wdata <= yo;
    @(posedge clk);
    cfg_we <= 1'b0;
    x_off = xo; y_off = yo;
  endtask

  function automatic clip_res_t mk(logic [OUT_W-1:0] fx, fy, sx, sy, logic v);
    clip_res_t r;
    r.fx = fx; r.fy = fy; r.sx = sx; r.sy = sy; r.vis = v;
    return r;
  endfunction

  // append one row to the directed table
  task automatic add_row(int nx, int ny, int n, logic chk, clip_res_t res);
    line_row_t r;
    r.nx = nx; r.ny = ny; r.n = n; r.chk = chk; r.res = res;
    rows = {rows, r};
  endtask

  initial begin
    clip_res_t none;
    logic [OFF_W-1:0] offs[4];
    int nx, ny, n, k;
    none = mk('0, '0, '0, '0, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: typed rows where obvious, otherwise predicted
    add_row(0, 0, 0, 1, none);                       // both coefficients zero
    add_row(0, 0, 255, 1, none);
    add_row(0, 1, 0, 1, mk(0, 0, ONE_FX, 0, 1));     // horizontal at y=0
    add_row(0, 1, 1, 1, mk(0, ONE_FX, ONE_FX, ONE_FX, 1));
    add_row(1, 0, 1, 1, mk(ONE_FX, 0, ONE_FX, ONE_FX, 1)); // vertical x=1
    add_row(0, -128, -256, 1, none);                 // outside square
    add_row(-128, 0, -128, 1, mk(ONE_FX, 0, ONE_FX, ONE_FX, 1));
    add_row(1, 1, 0, 1, none);                       // corner only, merged
    add_row(1, 1, 2, 1, none);
    add_row(1, 1, 1, 1, mk(0, ONE_FX, ONE_FX, 0, 1)); // diagonal
    add_row(1, -1, 0, 1, mk(0, 0, ONE_FX, ONE_FX, 1));
    add_row(127, 127, 255, 0, none);
    add_row(-128, -128, -256, 0, none);
    add_row(127, -128, 0, 0, none);
    add_row(3, 7, 5, 0, none);
    add_row(-3, 7, 2, 0, none);
    add_row(0, 127, 100, 0, none);
    add_row(127, 0, -1, 0, none);
    add_row(2, 3, 255, 0, none);
    add_row(-85, 127, -256, 0, none);
    foreach (rows[i]) send_line(rows[i].nx, rows[i].ny, rows[i].n, rows[i].chk, rows[i].res);
    drain();

    offs = '{24'h0, 24'hFF0000, 24'h123456, 24'h00FFFF};
    for (int ph = 0; ph < 6; ph++) begin
      set_offsets(offs[ph % 4], offs[(ph + 1 + ph / 4) % 4]);
      stall_pct = (ph == 0) ? 0 : (ph * 12);
      for (int i = 0; i < 150; i++) begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          // small coefficients with rhs near the square: mostly visible lines
          nx = $urandom_range(0, 16) - 8;
          ny = $urandom_range(0, 16) - 8;
          n = $urandom_range(0, 16) - 8;
        end else if (k < 65) begin
          nx = (k & 1) ? 0 : $urandom_range(0, 255) - 128;
          ny = (k & 1) ? $urandom_range(0, 255) - 128 : 0;
          n = $urandom_range(0, 511) - 256;
        end else if (k < 80) begin
          nx = $urandom_range(0, 255) - 128;
          ny = $urandom_range(0, 255) - 128;
          n = $urandom_range(0, 1) ? nx + ny - $urandom_range(0, 1) : $urandom_range(0, 2);
          if (n > 255) n = 255;
          if (n < -256) n = -256;
        end else begin
          nx = $urandom_range(0, 255) - 128;
          ny = $urandom_range(0, 255) - 128;
          n = $urandom_range(0, 511) - 256;
        end
        send_line(nx, ny, n, 1'b0, none);
      end
      drain();
    end

    if (n_errors == 0)
      $display("resonance_line_clip_unit_square verification clean");
    else
      $display("resonance_line_clip_unit_square verification failed");
    $finish;
  end

endmodule
